@@ hw/rtl/wlc_pkg.sv @@
// Package: shared types and constants of the wrapped line clipper.
`timescale 1ns / 1ps
package wlc_pkg;

	typedef struct packed {
		logic signed [31:0] start_lon;
		logic signed [31:0] start_lat;
		logic signed [31:0] end_lon;
		logic signed [31:0] end_lat;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] seg_start_x;
		logic signed [31:0] seg_start_y;
		logic signed [31:0] seg_end_x;
		logic signed [31:0] seg_end_y;
		logic               last_segment;
	} out_item_t;

	// Coordinates inside the block: 32 bits plus headroom for the 360 degree shifts
	localparam int CW = 34;

	// Outcode bits
	localparam logic [3:0] OC_WEST  = 4'h1;
	localparam logic [3:0] OC_EAST  = 4'h2;
	localparam logic [3:0] OC_SOUTH = 4'h4;
	localparam logic [3:0] OC_NORTH = 4'h8;

	// Register indexes
	localparam logic [1:0] REG_WEST  = 2'd0;
	localparam logic [1:0] REG_EAST  = 2'd1;
	localparam logic [1:0] REG_SOUTH = 2'd2;
	localparam logic [1:0] REG_NORTH = 2'd3;

	// One clip job handed from the front part to the back part
	typedef struct packed {
		logic signed [CW-1:0] x0;
		logic signed [CW-1:0] y0;
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
		logic                 last;   // last job of its item
	} job_t;

	typedef struct packed {
		logic signed [CW-1:0] west;
		logic signed [CW-1:0] east;
		logic signed [CW-1:0] south;
		logic signed [CW-1:0] north;
	} box_t;

endpackage

@@ hw/rtl/wlc_front.sv @@
// Front part: wraps longitudes and splits an item into one or two clip jobs.
`timescale 1ns / 1ps
module wlc_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  wlc_pkg::in_item_t  in_item,
	input  wlc_pkg::box_t      box,
	output logic               job_valid,
	input  logic               job_ready,
	output wlc_pkg::job_t      job
);
	import wlc_pkg::*;

	localparam logic signed [CW-1:0] DEG180 = CW'(180) <<< FRAC_BITS;
	localparam logic signed [CW-1:0] DEG360 = CW'(360) <<< FRAC_BITS;

	logic               busy_q;
	logic               second_q;
	job_t               j0_q, j1_q;
	logic               two_q;

	logic signed [CW-1:0] ax0, ay0, ax1, ay1, d;

	// Wrap and classify the incoming item
	always_comb begin
		ax0 = CW'(in_item.start_lon);
		ay0 = CW'(in_item.start_lat);
		ax1 = CW'(in_item.end_lon);
		ay1 = CW'(in_item.end_lat);
		if (ax0 < box.west) ax0 = ax0 + DEG360;
		if (ax1 < box.west) ax1 = ax1 + DEG360;
		d = ax0 - ax1;
		if (d < 0) d = -d;
	end

	assign in_ready  = !busy_q;
	assign job_valid = busy_q;
	assign job       = second_q ? j1_q : j0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			second_q <= 1'b0;
			two_q    <= 1'b0;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q   <= 1'b1;
				second_q <= 1'b0;
				two_q    <= d > DEG180;
			end
		end else if (job_ready) begin
			if (two_q && !second_q) second_q <= 1'b1;
			else begin
				busy_q   <= 1'b0;
				second_q <= 1'b0;
			end
		end
	end

	// Job payloads
	always_ff @(posedge clk) begin
		if (!busy_q && in_valid) begin
			j1_q.last  <= 1'b1;
			if (d > DEG180) begin
				j0_q.last <= 1'b0;
				if (ax0 > ax1) begin
					j0_q.x0 <= ax0;          j0_q.y0 <= ay0;
					j0_q.x1 <= ax1 + DEG360; j0_q.y1 <= ay1;
					j1_q.x0 <= ax0 - DEG360; j1_q.y0 <= ay0;
					j1_q.x1 <= ax1;          j1_q.y1 <= ay1;
				end else begin
					j0_q.x0 <= ax1;          j0_q.y0 <= ay1;
					j0_q.x1 <= ax0 + DEG360; j0_q.y1 <= ay0;
					j1_q.x0 <= ax1 - DEG360; j1_q.y0 <= ay1;
					j1_q.x1 <= ax0;          j1_q.y1 <= ay0;
				end
			end else begin
				j0_q.last <= 1'b1;
				j0_q.x0 <= ax0; j0_q.y0 <= ay0;
				j0_q.x1 <= ax1; j0_q.y1 <= ay1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) second_q |-> busy_q && two_q)
		else $error("second job without a split item");
	assert property (@(posedge clk) disable iff (!arst_n) (in_valid && in_ready) |=> busy_q)
		else $error("accepted item not held");
	assert property (@(posedge clk) disable iff (!arst_n) (busy_q && !two_q) |-> !second_q)
		else $error("single job item took a second job");

endmodule

@@ hw/rtl/wlc_queue.sv @@
// Short job queue between the front and the back parts.
`timescale 1ns / 1ps
module wlc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  wlc_pkg::job_t wr_job,
	output logic          rd_valid,
	input  logic          rd_ready,
	output wlc_pkg::job_t rd_job
);
	import wlc_pkg::*;

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_job   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= !wp_q;
			if (rd_valid && rd_ready) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q] <= wr_job;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 && wr_valid) |=> cnt_q == 2'd1)
		else $error("write into empty queue lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q == rp_q) |-> (cnt_q == 2'd0 || cnt_q == 2'd2))
		else $error("pointers and count disagree");

endmodule

@@ hw/rtl/wlc_div.sv @@
// Serial divider: 128 by 64 bit unsigned restoring division, one bit a cycle.
`timescale 1ns / 1ps
module wlc_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] dividend,
	input  logic [63:0]  divisor,
	output logic         done,
	output logic [63:0]  quot
);
	logic [127:0] num_q;
	logic [64:0]  rem_q;
	logic [63:0]  den_q;
	logic [63:0]  quot_q;
	logic [6:0]   cnt_q;
	logic         run_q;
	logic [64:0]  trial;

	assign trial = {rem_q[63:0], num_q[127]};
	assign quot  = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend;
			den_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (run_q) begin
			num_q <= num_q << 1;
			if (trial >= {1'b0, den_q}) begin
				rem_q  <= trial - {1'b0, den_q};
				quot_q <= {quot_q[62:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[62:0], 1'b0};
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !run_q)
		else $error("divider done while running");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> run_q)
		else $error("divider failed to start");
	assert property (@(posedge clk) disable iff (!arst_n) run_q |-> !done)
		else $error("done raised early");

endmodule

@@ hw/rtl/wlc_back.sv @@
// Back part: Cohen-Sutherland clip passes with a shared serial divider.
`timescale 1ns / 1ps
module wlc_back #(
	parameter int MAX_PASSES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  wlc_pkg::job_t      job,
	input  wlc_pkg::box_t      box,
	output logic               out_valid,
	input  logic               out_ready,
	output wlc_pkg::out_item_t out_item
);
	import wlc_pkg::*;

	localparam int PW = $clog2(MAX_PASSES + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_TEST = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_UPD  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t               state_q;
	logic signed [CW-1:0] x0_q, y0_q, x1_q, y1_q;
	logic                 last_q;
	logic [PW-1:0]        pass_q;
	logic                 pend_q;     // held piece is valid
	out_item_t            held_q;
	out_item_t            obuf_q;
	logic                 ovalid_q;

	// Outcodes
	function automatic logic [3:0] oc(input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y, input box_t b);
		logic [3:0] c;
		c = '0;
		if (x < b.west)  c = c | OC_WEST;
		if (x > b.east)  c = c | OC_EAST;
		if (y < b.south) c = c | OC_SOUTH;
		if (y > b.north) c = c | OC_NORTH;
		return c;
	endfunction

	logic [3:0] c0, c1, co;
	assign c0 = oc(x0_q, y0_q, box);
	assign c1 = oc(x1_q, y1_q, box);
	assign co = (c0 != 4'd0) ? c0 : c1;

	// Interpolation operands for the chosen edge
	logic signed [CW:0] base, delta, reach, span, edge_v;
	logic               alt_y;   // result goes to y, x takes the edge
	always_comb begin
		alt_y = 1'b0;
		if ((co & OC_NORTH) != 4'd0) begin
			base = (CW+1)'(x0_q); delta = (CW+1)'(x1_q) - (CW+1)'(x0_q);
			reach = (CW+1)'(box.north) - (CW+1)'(y0_q);
			span = (CW+1)'(y1_q) - (CW+1)'(y0_q); edge_v = (CW+1)'(box.north);
		end else if ((co & OC_SOUTH) != 4'd0) begin
			base = (CW+1)'(x0_q); delta = (CW+1)'(x1_q) - (CW+1)'(x0_q);
			reach = (CW+1)'(box.south) - (CW+1)'(y0_q);
			span = (CW+1)'(y1_q) - (CW+1)'(y0_q); edge_v = (CW+1)'(box.south);
		end else if ((co & OC_EAST) != 4'd0) begin
			alt_y = 1'b1;
			base = (CW+1)'(y0_q); delta = (CW+1)'(y1_q) - (CW+1)'(y0_q);
			reach = (CW+1)'(box.east) - (CW+1)'(x0_q);
			span = (CW+1)'(x1_q) - (CW+1)'(x0_q); edge_v = (CW+1)'(box.east);
		end else begin
			alt_y = 1'b1;
			base = (CW+1)'(y0_q); delta = (CW+1)'(y1_q) - (CW+1)'(y0_q);
			reach = (CW+1)'(box.west) - (CW+1)'(x0_q);
			span = (CW+1)'(x1_q) - (CW+1)'(x0_q); edge_v = (CW+1)'(box.west);
		end
	end

	// Pass operands, registered; the product is built over four partial products
	logic signed [CW:0] base_q, edge_q;
	logic               alt_q, side1_q, neg_q, zero_q;
	logic [CW:0]        ma_q, mb_q;
	logic [63:0]        den_q;
	logic [1:0]         mstep_q;
	logic [127:0]       prod_q;
	logic               dgo_q;      // product complete, divider starts
	logic               dstart;
	logic               ddone;
	logic [63:0]        dquot;

	function automatic logic [CW:0] absv(input logic signed [CW:0] v);
		return v < 0 ? -v : v;
	endfunction

	// One 18 by 18 bit slice product a step
	localparam int HW = (CW + 2) / 2;
	logic [HW-1:0] pa, pb;
	logic [2*HW-1:0] pp;
	always_comb begin
		pa = mstep_q[1] ? HW'(ma_q >> HW) : HW'(ma_q);
		pb = mstep_q[0] ? HW'(mb_q >> HW) : HW'(mb_q);
		pp = pa * pb;
	end

	wlc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dstart),
		.dividend (prod_q),
		.divisor  (den_q),
		.done     (ddone),
		.quot     (dquot)
	);

	assign dstart    = dgo_q;
	assign job_ready = (state_q == ST_IDLE);
	assign out_valid = ovalid_q;
	assign out_item  = obuf_q;

	logic signed [CW:0] result;
	always_comb begin
		if (zero_q) result = base_q;
		else if (neg_q) result = base_q - (CW+1)'(dquot);
		else result = base_q + (CW+1)'(dquot);
	end

	// Output register: takes a piece once the next one (or item end) is known
	logic emit;
	out_item_t emit_item;

	always_comb begin
		emit      = 1'b0;
		emit_item = held_q;
		if (pend_q && (!ovalid_q || out_ready)) begin
			if (state_q == ST_TEST && (c0 | c1) == 4'd0) emit = 1'b1;
			if (state_q == ST_OUT) begin
				emit = 1'b1;
				emit_item.last_segment = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			obuf_q   <= '0;
		end else if (emit) begin
			obuf_q   <= emit_item;
			ovalid_q <= 1'b1;
		end else if (out_valid && out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Clip sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
			mstep_q <= '0;
			dgo_q   <= 1'b0;
			pass_q  <= '0;
			x0_q    <= '0;
			y0_q    <= '0;
			x1_q    <= '0;
			y1_q    <= '0;
			last_q  <= 1'b0;
			held_q  <= '0;
			base_q  <= '0;
			edge_q  <= '0;
			alt_q   <= 1'b0;
			side1_q <= 1'b0;
			ma_q    <= '0;
			mb_q    <= '0;
			den_q   <= '0;
			zero_q  <= 1'b0;
			neg_q   <= 1'b0;
			prod_q  <= '0;
		end else begin
			dgo_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						x0_q <= job.x0; y0_q <= job.y0;
						x1_q <= job.x1; y1_q <= job.y1;
						last_q  <= job.last;
						pass_q  <= '0;
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if ((c0 | c1) == 4'd0) begin
						// Accepted: previous held piece goes out unmarked
						if (!ovalid_q || out_ready) begin
							held_q <= '{seg_start_x: x0_q[31:0], seg_start_y: y0_q[31:0],
								seg_end_x: x1_q[31:0], seg_end_y: y1_q[31:0],
								last_segment: 1'b0};
							pend_q  <= 1'b1;
							state_q <= last_q ? ST_OUT : ST_IDLE;
						end
					end else if ((c0 & c1) != 4'd0 || pass_q == PW'(MAX_PASSES)) begin
						state_q <= last_q ? ST_OUT : ST_IDLE;
					end else begin
						base_q  <= base;
						edge_q  <= edge_v;
						alt_q   <= alt_y;
						side1_q <= (c0 == 4'd0);
						ma_q    <= absv(delta);
						mb_q    <= absv(reach);
						den_q   <= 64'(absv(span));
						zero_q  <= (delta == 0) || (reach == 0) || (span == 0);
						neg_q   <= ((delta < 0) != (reach < 0)) != (span < 0);
						prod_q  <= '0;
						mstep_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= prod_q + (128'(pp) << (HW * (32'(mstep_q[1]) + 32'(mstep_q[0]))));
					mstep_q <= mstep_q + 2'd1;
					if (mstep_q == 2'd3) begin
						dgo_q   <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (ddone) state_q <= ST_UPD;
				end
				ST_UPD: begin
					pass_q <= pass_q + PW'(1);
					if (side1_q) begin
						x1_q <= alt_q ? edge_q[CW-1:0] : result[CW-1:0];
						y1_q <= alt_q ? result[CW-1:0] : edge_q[CW-1:0];
					end else begin
						x0_q <= alt_q ? edge_q[CW-1:0] : result[CW-1:0];
						y0_q <= alt_q ? result[CW-1:0] : edge_q[CW-1:0];
					end
					state_q <= ST_TEST;
				end
				ST_OUT: begin
					// Item ends: release held piece marked as last
					if (!pend_q) state_q <= ST_IDLE;
					else if (!ovalid_q || out_ready) begin
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && mstep_q == 2'd3) |=> state_q == ST_DIV)
		else $error("product not handed to divider");
	assert property (@(posedge clk) disable iff (!arst_n) ddone |-> state_q == ST_DIV)
		else $error("divider result unexpected");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !pend_q) |=> state_q == ST_IDLE)
		else $error("empty item close stalled");
	assert property (@(posedge clk) disable iff (!arst_n) pass_q <= PW'(MAX_PASSES))
		else $error("pass count beyond limit");

endmodule

@@ hw/rtl/wrapped_line_clip_2d_top.sv @@
// Top level of the wrapped 2D line clipper.
// Usage:
//   Input channel in_valid/in_ready carries one segment item (lon/lat at both
//   ends, Q15.16). Output channel out_valid/out_ready carries zero, one or two
//   clipped pieces per item; the final piece has last_segment set.
//   Configuration: cfg_we writes cfg_data to box register cfg_index
//   (west, east, south, north); write only while the block is idle.
//   Clip pass: each pass runs one test, four multiply steps, the one-bit-a-cycle
//   128 by 64 bit serial divider and one update; a job runs at most eight
//   passes and nine tests, and the last job of an item ends in a closing state
//   that releases the held piece. A split item runs two jobs.
//   Throughput: one job at a time in the back part; the front part splits
//   the next item into jobs while the back part still works.
//   Reset: arst_n clears all control state and loads the box with
//   -180/+180 degrees longitude and -90/+90 degrees latitude.
//   Output stall: the result register holds its item and one more piece is
//   held inside; the back part then waits, the job queue fills, and the front
//   stops taking items.
`timescale 1ns / 1ps
module wrapped_line_clip_2d_top #(
	parameter int MAX_PASSES = 8,
	parameter int FRAC_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  wlc_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output wlc_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import wlc_pkg::*;

	box_t box_q;
	job_t fj, qj;
	logic fv, fr, qv, qr;

	// Box registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q.west  <= -(CW'(180) <<< FRAC_BITS);
			box_q.east  <= CW'(180) <<< FRAC_BITS;
			box_q.south <= -(CW'(90) <<< FRAC_BITS);
			box_q.north <= CW'(90) <<< FRAC_BITS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WEST:  box_q.west  <= CW'($signed(cfg_data));
				REG_EAST:  box_q.east  <= CW'($signed(cfg_data));
				REG_SOUTH: box_q.south <= CW'($signed(cfg_data));
				REG_NORTH: box_q.north <= CW'($signed(cfg_data));
				default:   box_q <= box_q;
			endcase
		end
	end

	wlc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .box(box_q), .job_valid(fv), .job_ready(fr), .job(fj)
	);

	wlc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(fv), .wr_ready(fr), .wr_job(fj),
		.rd_valid(qv), .rd_ready(qr), .rd_job(qj)
	);

	wlc_back #(.MAX_PASSES(MAX_PASSES)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(qv), .job_ready(qr), .job(qj),
		.box(box_q), .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

endmodule
